FILE: design/prc_pkg.sv
// Package for the perspective remap coordinate block: widths, register codes,
// reset values and the shared types. No dependencies.
package prc_pkg;

  localparam int unsigned PIX_W    = 10;
  localparam int unsigned COEF_W   = 32;
  localparam int unsigned REG_W    = 64;
  localparam int unsigned ADDR_W   = 6;
  localparam int unsigned PROD_W   = COEF_W + PIX_W + 1;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned MAG_W    = SUM_W;
  localparam int unsigned FRAC_SH  = 15;
  localparam int unsigned DVD_W    = MAG_W + FRAC_SH;
  localparam int unsigned RES_W    = DVD_W + 2;
  localparam int unsigned INT_W    = 16;
  localparam int unsigned FRC_W    = 5;
  localparam int unsigned LANES    = 2;

  localparam int unsigned LIN_STAGES = 4;
  localparam int unsigned RND_STAGES = 3;
  localparam int unsigned POST_LAT   = DVD_W + RND_STAGES;
  localparam int unsigned LATENCY    = LIN_STAGES + POST_LAT;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  localparam logic [REG_W-1:0]  X_NUM_LIN_RST = 64'h0010_0000_0000_0000;
  localparam logic [COEF_W-1:0] X_NUM_OFF_RST = 32'h0000_0000;
  localparam logic [REG_W-1:0]  Y_NUM_LIN_RST = 64'h0000_0000_0010_0000;
  localparam logic [COEF_W-1:0] Y_NUM_OFF_RST = 32'h0000_0000;
  localparam logic [REG_W-1:0]  DEN_LIN_RST   = 64'h0000_0000_0000_0000;
  localparam logic [COEF_W-1:0] DEN_OFF_RST   = 32'h4000_0000;

  typedef enum logic [2:0] {
    REG_X_NUM_LIN,
    REG_X_NUM_OFF,
    REG_Y_NUM_LIN,
    REG_Y_NUM_OFF,
    REG_DEN_LIN,
    REG_DEN_OFF
  } prc_reg_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] m11;
    logic signed [COEF_W-1:0] m12;
    logic signed [COEF_W-1:0] m13;
    logic signed [COEF_W-1:0] m21;
    logic signed [COEF_W-1:0] m22;
    logic signed [COEF_W-1:0] m23;
    logic signed [COEF_W-1:0] m31;
    logic signed [COEF_W-1:0] m32;
    logic signed [COEF_W-1:0] m33;
  } prc_coef_t;

  typedef struct packed {
    logic             zero;
    logic [LANES-1:0] neg;
  } prc_side_t;

endpackage

FILE: design/prc_regs.sv
// Configuration registers behind the APB-style port.
// Depends on prc_pkg.
module prc_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prc_pkg::ADDR_W-1:0]   paddr,
  input  logic [prc_pkg::REG_W-1:0]    pwdata,
  output logic [prc_pkg::REG_W-1:0]    prdata,
  output logic                         pready,
  output prc_pkg::prc_coef_t           coef_o
);
  import prc_pkg::*;

  logic [REG_W-1:0]  x_num_lin_q;
  logic [COEF_W-1:0] x_num_off_q;
  logic [REG_W-1:0]  y_num_lin_q;
  logic [COEF_W-1:0] y_num_off_q;
  logic [REG_W-1:0]  den_lin_q;
  logic [COEF_W-1:0] den_off_q;
  prc_reg_e          idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = prc_reg_e'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_num_lin_q <= X_NUM_LIN_RST;
      x_num_off_q <= X_NUM_OFF_RST;
      y_num_lin_q <= Y_NUM_LIN_RST;
      y_num_off_q <= Y_NUM_OFF_RST;
      den_lin_q   <= DEN_LIN_RST;
      den_off_q   <= DEN_OFF_RST;
    end else if (wr_en) begin
      case (idx)
        REG_X_NUM_LIN: x_num_lin_q <= pwdata;
        REG_X_NUM_OFF: x_num_off_q <= pwdata[COEF_W-1:0];
        REG_Y_NUM_LIN: y_num_lin_q <= pwdata;
        REG_Y_NUM_OFF: y_num_off_q <= pwdata[COEF_W-1:0];
        REG_DEN_LIN:   den_lin_q   <= pwdata;
        REG_DEN_OFF:   den_off_q   <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_X_NUM_LIN: prdata = x_num_lin_q;
      REG_X_NUM_OFF: prdata = REG_W'(x_num_off_q);
      REG_Y_NUM_LIN: prdata = y_num_lin_q;
      REG_Y_NUM_OFF: prdata = REG_W'(y_num_off_q);
      REG_DEN_LIN:   prdata = den_lin_q;
      REG_DEN_OFF:   prdata = REG_W'(den_off_q);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    coef_o.m11 = x_num_lin_q[REG_W-1:COEF_W];
    coef_o.m12 = x_num_lin_q[COEF_W-1:0];
    coef_o.m13 = x_num_off_q;
    coef_o.m21 = y_num_lin_q[REG_W-1:COEF_W];
    coef_o.m22 = y_num_lin_q[COEF_W-1:0];
    coef_o.m23 = y_num_off_q;
    coef_o.m31 = den_lin_q[REG_W-1:COEF_W];
    coef_o.m32 = den_lin_q[COEF_W-1:0];
    coef_o.m33 = den_off_q;
  end

endmodule

FILE: design/prc_lin.sv
// Front end: clamps the pixel, forms the three linear forms in registered product and sum stages
// and hands magnitudes and signs to the divider. Depends on prc_pkg.
module prc_lin #(
  parameter int unsigned MAX_WIDTH  = prc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = prc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         vld_i,
  input  logic [prc_pkg::PIX_W-1:0]                    pixel_x_i,
  input  logic [prc_pkg::PIX_W-1:0]                    pixel_y_i,
  input  prc_pkg::prc_coef_t                           coef_i,
  output logic                                         vld_o,
  output prc_pkg::prc_side_t                           side_o,
  output logic [prc_pkg::LANES-1:0][prc_pkg::DVD_W-1:0] dvd_o,
  output logic [prc_pkg::MAG_W-1:0]                    dsr_o
);
  import prc_pkg::*;

  logic [PIX_W-1:0]         x_d, y_d, x_q, y_q;
  logic [3:0]               vld_q;
  logic signed [PROD_W-1:0] p_q [6];
  logic signed [SUM_W-1:0]  nx_q, ny_q, den_q;
  logic signed [SUM_W-1:0]  nx_d, ny_d, den_d;
  logic [MAG_W-1:0]         mx, my, md;
  logic                     gx, gy, gd;
  prc_side_t                side_d, side_q;
  logic [LANES-1:0][DVD_W-1:0] dvd_q;
  logic [MAG_W-1:0]         dsr_q;
  logic signed [PIX_W:0]    xs, ys;

  always_comb begin
    x_d = pixel_x_i;
    y_d = pixel_y_i;
    if (int'(pixel_x_i) > int'(MAX_WIDTH) - 1)  x_d = PIX_W'(MAX_WIDTH - 1);
    if (int'(pixel_y_i) > int'(MAX_HEIGHT) - 1) y_d = PIX_W'(MAX_HEIGHT - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  assign xs = $signed({1'b0, x_q});
  assign ys = $signed({1'b0, y_q});

  always_comb begin
    nx_d  = SUM_W'(p_q[0]) + SUM_W'(p_q[1]) + SUM_W'(coef_i.m13);
    ny_d  = SUM_W'(p_q[2]) + SUM_W'(p_q[3]) + SUM_W'(coef_i.m23);
    den_d = SUM_W'(p_q[4]) + SUM_W'(p_q[5]) + SUM_W'(coef_i.m33);
    gx = nx_q[SUM_W-1];
    gy = ny_q[SUM_W-1];
    gd = den_q[SUM_W-1];
    mx = gx ? MAG_W'(-nx_q)  : MAG_W'(nx_q);
    my = gy ? MAG_W'(-ny_q)  : MAG_W'(ny_q);
    md = gd ? MAG_W'(-den_q) : MAG_W'(den_q);
    side_d.zero = (den_q == '0);
    side_d.neg  = {gy ^ gd, gx ^ gd};
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    p_q[0] <= coef_i.m11 * xs;
    p_q[1] <= coef_i.m12 * ys;
    p_q[2] <= coef_i.m21 * xs;
    p_q[3] <= coef_i.m22 * ys;
    p_q[4] <= coef_i.m31 * xs;
    p_q[5] <= coef_i.m32 * ys;
    nx_q   <= nx_d;
    ny_q   <= ny_d;
    den_q  <= den_d;
    dvd_q  <= {{mx, FRAC_SH'(0)}, {my, FRAC_SH'(0)}} == '0 ? '0 :
              {{my, FRAC_SH'(0)}, {mx, FRAC_SH'(0)}};
    dsr_q  <= md;
    side_q <= side_d;
  end

  assign vld_o  = vld_q[3];
  assign side_o = side_q;
  assign dvd_o  = dvd_q;
  assign dsr_o  = dsr_q;

endmodule

FILE: design/prc_div.sv
// Pipelined restoring divider, one quotient bit per stage, both lanes
// sharing one divisor. Depends on prc_pkg.
module prc_div (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          vld_i,
  input  prc_pkg::prc_side_t                            side_i,
  input  logic [prc_pkg::LANES-1:0][prc_pkg::DVD_W-1:0] dvd_i,
  input  logic [prc_pkg::MAG_W-1:0]                     dsr_i,
  output logic                                          vld_o,
  output prc_pkg::prc_side_t                            side_o,
  output logic [prc_pkg::LANES-1:0][prc_pkg::DVD_W-1:0] quo_o,
  output logic [prc_pkg::LANES-1:0][prc_pkg::MAG_W-1:0] rem_o,
  output logic [prc_pkg::MAG_W-1:0]                     dsr_o
);
  import prc_pkg::*;

  logic                              vld_q  [DVD_W];
  prc_side_t                         side_q [DVD_W];
  logic [MAG_W-1:0]                  dsr_q  [DVD_W];
  logic [LANES-1:0][MAG_W-1:0]       rem_q  [DVD_W];
  logic [LANES-1:0][DVD_W-1:0]       dq_q   [DVD_W];

  for (genvar k = 0; k < DVD_W; k++) begin : g_stg
    logic                        vin;
    prc_side_t                   sin;
    logic [MAG_W-1:0]            din;
    logic [LANES-1:0][MAG_W-1:0] pin;
    logic [LANES-1:0][DVD_W-1:0] qin;
    logic [LANES-1:0][MAG_W-1:0] rem_d;
    logic [LANES-1:0][DVD_W-1:0] dq_d;

    if (k == 0) begin : g_first
      assign vin = vld_i;
      assign sin = side_i;
      assign din = dsr_i;
      assign pin = '0;
      assign qin = dvd_i;
    end else begin : g_next
      assign vin = vld_q[k-1];
      assign sin = side_q[k-1];
      assign din = dsr_q[k-1];
      assign pin = rem_q[k-1];
      assign qin = dq_q[k-1];
    end

    always_comb begin
      logic [MAG_W:0] t, diff;
      logic           ge;
      for (int l = 0; l < LANES; l++) begin
        t        = {pin[l], qin[l][DVD_W-1]};
        diff     = t - {1'b0, din};
        ge       = (t >= {1'b0, din});
        rem_d[l] = ge ? diff[MAG_W-1:0] : t[MAG_W-1:0];
        dq_d[l]  = {qin[l][DVD_W-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= sin;
      dsr_q[k]  <= din;
      rem_q[k]  <= rem_d;
      dq_q[k]   <= dq_d;
    end
  end

  assign vld_o  = vld_q[DVD_W-1];
  assign side_o = side_q[DVD_W-1];
  assign dsr_o  = dsr_q[DVD_W-1];
  assign rem_o  = rem_q[DVD_W-1];
  assign quo_o  = dq_q[DVD_W-1];

endmodule

FILE: design/prc_round.sv
// Signed floor fix-up, round half to even, split into saturated integer
// part and 1/32 fraction for one coordinate. Depends on prc_pkg.
module prc_round (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        vld_i,
  input  logic                        zero_i,
  input  logic                        neg_i,
  input  logic [prc_pkg::DVD_W-1:0]   quo_i,
  input  logic [prc_pkg::MAG_W-1:0]   rem_i,
  input  logic [prc_pkg::MAG_W-1:0]   dsr_i,
  output logic                        vld_o,
  output logic signed [prc_pkg::INT_W-1:0] int_o,
  output logic [prc_pkg::FRC_W-1:0]   frac_o
);
  import prc_pkg::*;

  localparam int unsigned IP_W = RES_W - FRC_W;

  logic [2:0]              vld_q;
  logic                    z1_q, z2_q;
  logic signed [RES_W-1:0] q_d, q_q, r_d, r_q;
  logic [MAG_W-1:0]        rm_d, rm_q, d1_q;
  logic                    inc;
  logic [MAG_W:0]          twice;
  logic signed [IP_W-1:0]  ip;
  logic                    in_rng;
  logic signed [INT_W-1:0] int_d, int_q;
  logic [FRC_W-1:0]        frac_d, frac_q;

  always_comb begin
    if (neg_i && rem_i != '0) begin
      q_d  = ~{2'b00, quo_i};
      rm_d = dsr_i - rem_i;
    end else if (neg_i) begin
      q_d  = -{2'b00, quo_i};
      rm_d = rem_i;
    end else begin
      q_d  = {2'b00, quo_i};
      rm_d = rem_i;
    end
  end

  always_comb begin
    twice = {rm_q, 1'b0};
    inc   = (twice > {1'b0, d1_q}) || ((twice == {1'b0, d1_q}) && q_q[0]);
    r_d   = q_q + RES_W'(inc);
  end

  always_comb begin
    ip     = r_q[RES_W-1:FRC_W];
    in_rng = (ip[IP_W-1:INT_W-1] == '0) || (ip[IP_W-1:INT_W-1] == '1);
    if (z2_q) begin
      int_d  = '0;
      frac_d = '0;
    end else begin
      int_d  = in_rng ? ip[INT_W-1:0] : {ip[IP_W-1], {(INT_W-1){~ip[IP_W-1]}}};
      frac_d = r_q[FRC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    q_q    <= q_d;
    rm_q   <= rm_d;
    d1_q   <= dsr_i;
    z1_q   <= zero_i;
    r_q    <= r_d;
    z2_q   <= z1_q;
    int_q  <= int_d;
    frac_q <= frac_d;
  end

  assign vld_o  = vld_q[2];
  assign int_o  = int_q;
  assign frac_o = frac_q;

endmodule

FILE: design/perspective_remap_coordinate.sv
// Perspective remap coordinate generator: an item runs from the start edge
// to the result strobe through 4 front-end stages, 60 divider stages and 3
// rounding stages; one item per cycle sustained, busy never rises.
// Reset clears every valid bit and loads the identity homography.
// The receiver cannot stall: each result shows for one cycle only.
module perspective_remap_coordinate #(
  parameter int unsigned MAX_WIDTH  = prc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = prc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [prc_pkg::PIX_W-1:0]        pixel_x_i,
  input  logic [prc_pkg::PIX_W-1:0]        pixel_y_i,
  output logic                             valid_o,
  output logic signed [prc_pkg::INT_W-1:0] src_x_int_o,
  output logic [prc_pkg::FRC_W-1:0]        src_x_frac_o,
  output logic signed [prc_pkg::INT_W-1:0] src_y_int_o,
  output logic [prc_pkg::FRC_W-1:0]        src_y_frac_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [prc_pkg::ADDR_W-1:0]       paddr,
  input  logic [prc_pkg::REG_W-1:0]        pwdata,
  output logic [prc_pkg::REG_W-1:0]        prdata,
  output logic                             pready
);
  import prc_pkg::*;

  prc_coef_t                   coef;
  logic                        lin_vld, div_vld, vld_x, vld_y;
  prc_side_t                   lin_side, div_side;
  logic [LANES-1:0][DVD_W-1:0] lin_dvd, div_quo;
  logic [LANES-1:0][MAG_W-1:0] div_rem;
  logic [MAG_W-1:0]            lin_dsr, div_dsr;

  assign busy = 1'b0;

  prc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  prc_lin #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_lin (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (start & ~busy),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .coef_i    (coef),
    .vld_o     (lin_vld),
    .side_o    (lin_side),
    .dvd_o     (lin_dvd),
    .dsr_o     (lin_dsr)
  );

  prc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (lin_vld),
    .side_i (lin_side),
    .dvd_i  (lin_dvd),
    .dsr_i  (lin_dsr),
    .vld_o  (div_vld),
    .side_o (div_side),
    .quo_o  (div_quo),
    .rem_o  (div_rem),
    .dsr_o  (div_dsr)
  );

  prc_round u_rnd_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (div_vld),
    .zero_i (div_side.zero),
    .neg_i  (div_side.neg[0]),
    .quo_i  (div_quo[0]),
    .rem_i  (div_rem[0]),
    .dsr_i  (div_dsr),
    .vld_o  (vld_x),
    .int_o  (src_x_int_o),
    .frac_o (src_x_frac_o)
  );

  prc_round u_rnd_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (div_vld),
    .zero_i (div_side.zero),
    .neg_i  (div_side.neg[1]),
    .quo_i  (div_quo[1]),
    .rem_i  (div_rem[1]),
    .dsr_i  (div_dsr),
    .vld_o  (vld_y),
    .int_o  (src_y_int_o),
    .frac_o (src_y_frac_o)
  );

  assign valid_o = vld_x & vld_y;

  a_out_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start & ~busy, LATENCY))
    else $error("result strobe without an accepted item");

  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(lin_vld && lin_side.zero, POST_LAT)) |->
      (src_x_int_o == '0 && src_x_frac_o == '0 &&
       src_y_int_o == '0 && src_y_frac_o == '0))
    else $error("zero denominator gave a nonzero result");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_x == vld_y)
    else $error("rounding lanes out of step");

endmodule
